>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation and status codes, and the controller states that are
// shared by the deque and its testbench.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int CAPACITY    = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DATA
  } state_e;

  // Slot arithmetic modulo the capacity.
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(CAPACITY - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) begin
      res = IDX_W'(CAPACITY - 1);
    end else begin
      res = idx - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

>>> rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic dual-read RAM
// One write port and two read ports, with the read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_b_i,
  output logic [WIDTH-1:0]                 rd_data_a_o,
  output logic [WIDTH-1:0]                 rd_data_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_a_q;
  logic [WIDTH-1:0] rd_data_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_a_q <= mem_q[rd_addr_a_i];
      rd_data_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// A deque of signed 32-bit values kept in a circular buffer in RAM. Each
// transaction pushes or pops at either end, or only queries, and yields one
// result with the front and back values, the entry count and a status.
//
//   Channel  Handshake                Payload
//   input    in_valid_i / in_stall_o  op_i, push_value_i
//   output   out_valid_o / out_stall_i front_value_o, back_value_o,
//                                     entry_count_o, is_empty_o, status_o
//
// An operation runs through the states ST_IDLE (accept and write), ST_READ (RAM
// read of the front and back slots) and ST_DATA (loading of the output register).
// The input stalls in the read and load states, so the deque takes no new
// transaction until the last one has been loaded into the output register.
// Reset sets the front pointer to slot 0, the back pointer to the last slot and
// the count to zero; the RAM contents are not cleared. A stalled output holds the
// load state until the output register is free.
module double_ended_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic signed [31:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]  entry_count_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o
);

  localparam int IDX_W = deq_pkg::IDX_W;
  localparam int CNT_W = deq_pkg::CNT_W;
  localparam int DW    = deq_pkg::DATA_W;

  deq_pkg::state_e  state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] back_q, back_d;
  logic [CNT_W-1:0] count_q, count_d;
  deq_pkg::status_e status_q, status_d;

  logic             out_valid_q, out_valid_d;
  logic [DW-1:0]    front_val_q, back_val_q;
  logic [deq_pkg::COUNT_OUT_W-1:0] count_out_q;
  logic             empty_q;
  deq_pkg::status_e status_out_q;

  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [DW-1:0]    rd_front, rd_back;
  logic             is_full, is_none;
  deq_pkg::op_e     op;

  assign op        = deq_pkg::op_e'(op_i);
  assign is_full   = (count_q == CNT_W'(deq_pkg::CAPACITY));
  assign is_none   = (count_q == '0);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = deq_pkg::ST_READ;
        end
      end
      deq_pkg::ST_READ: begin
        state_d = deq_pkg::ST_DATA;
      end
      deq_pkg::ST_DATA: begin
        if (out_free) begin
          state_d = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      deq_pkg::ST_IDLE: in_stall_o = 1'b0;
      deq_pkg::ST_READ: rd_en      = 1'b1;
      deq_pkg::ST_DATA: out_load   = out_free;
      default:          in_stall_o = 1'b1;
    endcase
  end

  // Pointer, count and RAM write update for an accepted transaction.
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = deq_pkg::idx_next(back_q);
    if (in_accept) begin
      status_d = deq_pkg::STATUS_OK;
      unique case (op)
        deq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            wr_en   = 1'b1;
            wr_addr = deq_pkg::idx_next(back_q);
            back_d  = deq_pkg::idx_next(back_q);
            count_d = count_q + CNT_W'(1);
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            wr_en   = 1'b1;
            wr_addr = deq_pkg::idx_prev(front_q);
            front_d = deq_pkg::idx_prev(front_q);
            count_d = count_q + CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (is_none) begin
            status_d = deq_pkg::STATUS_UNDERFLOW;
          end else begin
            front_d = deq_pkg::idx_next(front_q);
            count_d = count_q - CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (is_none) begin
            status_d = deq_pkg::STATUS_UNDERFLOW;
          end else begin
            back_d  = deq_pkg::idx_prev(back_q);
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = deq_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      front_q     <= '0;
      back_q      <= IDX_W'(deq_pkg::CAPACITY - 1);
      count_q     <= '0;
      status_q    <= deq_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      front_val_q  <= is_none ? '1 : rd_front;
      back_val_q   <= is_none ? '1 : rd_back;
      count_out_q  <= deq_pkg::COUNT_OUT_W'(count_q);
      empty_q      <= is_none;
      status_out_q <= status_q;
    end
  end

  deq_ram #(
    .WIDTH (DW),
    .DEPTH (deq_pkg::CAPACITY)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (push_value_i),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (front_q),
    .rd_addr_b_i (back_q),
    .rd_data_a_o (rd_front),
    .rd_data_b_o (rd_back)
  );

  assign out_valid_o   = out_valid_q;
  assign front_value_o = front_val_q;
  assign back_value_o  = back_val_q;
  assign entry_count_o = count_out_q;
  assign is_empty_o    = empty_q;
  assign status_o      = status_out_q;

  // The back pointer must always sit one slot before the front pointer plus
  // the count.
  logic [IDX_W:0] chk_sum;
  logic [IDX_W:0] chk_slot;
  assign chk_sum  = {1'b0, front_q} + (IDX_W+1)'(count_q) + (IDX_W+1)'(deq_pkg::CAPACITY - 1);
  assign chk_slot = (chk_sum >= (IDX_W+1)'(deq_pkg::CAPACITY)) ?
                    chk_sum - (IDX_W+1)'(deq_pkg::CAPACITY) : chk_sum;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(deq_pkg::CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_back_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_q == chk_slot[IDX_W-1:0])
    else $error("Back pointer disagrees with front pointer and count.");

  a_overflow_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_full && (op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT))
      |=> (count_q == $past(count_q) && front_q == $past(front_q)))
    else $error("A push on a full deque changed the state.");

  a_underflow_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_none && (op == deq_pkg::OP_POP_FRONT || op == deq_pkg::OP_POP_BACK))
      |=> (count_q == '0 && front_q == $past(front_q)))
    else $error("A pop on an empty deque changed the state.");

endmodule

>>> bench/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop and query transactions into the deque and predicts each
// result from a software copy of the circular buffer. A short table of
// directed operations covers the empty and full edges and the extreme values.
// Random bursts then fill, drain and mix the deque under four phases of sender idling and receiver stalls.
// Every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

  localparam int DW  = deq_pkg::DATA_W;
  localparam int CW  = deq_pkg::COUNT_OUT_W;
  localparam int OPW = deq_pkg::OP_W;

  typedef struct packed {
    logic signed [DW-1:0] front_value;
    logic signed [DW-1:0] back_value;
    logic [CW-1:0]        entry_count;
    logic                 is_empty;
    deq_pkg::status_e     status;
  } deque_view_t;

  typedef struct {
    logic [OPW-1:0]       op;
    logic signed [DW-1:0] value;
    int                   reps;
    bit                   typed;
    deque_view_t          want;
  } directed_row_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_e;

  localparam logic [OPW-1:0]       OP_SPARE_5 = 3'd5;
  localparam logic [OPW-1:0]       OP_SPARE_7 = 3'd7;
  localparam logic signed [DW-1:0] EMPTY_MARK = -32'sd1;
  localparam logic signed [DW-1:0] MAX_VAL    = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] MIN_VAL    = 32'sh8000_0000;
  localparam deque_view_t          NO_CHECK   = '0;
  localparam int RANDOM_PER_PHASE = 420;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DIRECTED_ROWS    = 13;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [OPW-1:0]              op_i         = deq_pkg::OP_QUERY;
  logic signed [DW-1:0]        push_value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic signed [DW-1:0]        front_value_o;
  logic signed [DW-1:0]        back_value_o;
  logic [CW-1:0]               entry_count_o;
  logic                        is_empty_o;
  logic [deq_pkg::STATUS_W-1:0] status_o;

  logic signed [DW-1:0] deque_slots [deq_pkg::CAPACITY];
  int                   head_slot = 0;
  int                   live_count = 0;
  deque_view_t          predicted_views [$];
  int                   mismatch_count = 0;
  int                   sender_idle_pct = 0;
  int                   receiver_stall_pct = 0;
  bit                   timed_out = 1'b0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{deq_pkg::OP_QUERY,      '0,          1, 1'b1,
      '{EMPTY_MARK, EMPTY_MARK, 5'd0, 1'b1, deq_pkg::STATUS_OK}},
    '{deq_pkg::OP_POP_FRONT,  '0,          1, 1'b1,
      '{EMPTY_MARK, EMPTY_MARK, 5'd0, 1'b1, deq_pkg::STATUS_UNDERFLOW}},
    '{deq_pkg::OP_POP_BACK,   '0,          1, 1'b1,
      '{EMPTY_MARK, EMPTY_MARK, 5'd0, 1'b1, deq_pkg::STATUS_UNDERFLOW}},
    '{OP_SPARE_5,             32'sh5A5A_5A5A, 1, 1'b1,
      '{EMPTY_MARK, EMPTY_MARK, 5'd0, 1'b1, deq_pkg::STATUS_OK}},
    '{deq_pkg::OP_PUSH_BACK,  MAX_VAL,     1, 1'b1,
      '{MAX_VAL, MAX_VAL, 5'd1, 1'b0, deq_pkg::STATUS_OK}},
    '{deq_pkg::OP_PUSH_FRONT, MIN_VAL,     1, 1'b1,
      '{MIN_VAL, MAX_VAL, 5'd2, 1'b0, deq_pkg::STATUS_OK}},
    '{deq_pkg::OP_POP_BACK,   '0,          1, 1'b0, NO_CHECK},
    '{deq_pkg::OP_POP_FRONT,  '0,          1, 1'b1,
      '{EMPTY_MARK, EMPTY_MARK, 5'd0, 1'b1, deq_pkg::STATUS_OK}},
    '{deq_pkg::OP_PUSH_FRONT, EMPTY_MARK,  1, 1'b1,
      '{EMPTY_MARK, EMPTY_MARK, 5'd1, 1'b0, deq_pkg::STATUS_OK}},
    '{deq_pkg::OP_PUSH_FRONT, 32'sd100,    7, 1'b0, NO_CHECK},
    '{deq_pkg::OP_PUSH_BACK,  -32'sd100,   8, 1'b0, NO_CHECK},
    '{deq_pkg::OP_PUSH_BACK,  32'sd1,      1, 1'b0, NO_CHECK},
    '{deq_pkg::OP_PUSH_FRONT, 32'sd2,      1, 1'b0, NO_CHECK}
  };

  double_ended_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  function automatic deque_view_t apply_deque_op(input logic [OPW-1:0] op,
                                                 input logic signed [DW-1:0] value);
    deque_view_t res;
    res.status = deq_pkg::STATUS_OK;
    case (op)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (live_count >= deq_pkg::CAPACITY) begin
          res.status = deq_pkg::STATUS_OVERFLOW;
        end else if (op == deq_pkg::OP_PUSH_BACK) begin
          deque_slots[(head_slot + live_count) % deq_pkg::CAPACITY] = value;
          live_count++;
        end else begin
          head_slot = (head_slot + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
          deque_slots[head_slot] = value;
          live_count++;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (live_count == 0) begin
          res.status = deq_pkg::STATUS_UNDERFLOW;
        end else begin
          if (op == deq_pkg::OP_POP_FRONT) begin
            head_slot = (head_slot + 1) % deq_pkg::CAPACITY;
          end
          live_count--;
        end
      end
      default: ;
    endcase
    if (live_count == 0) begin
      res.front_value = EMPTY_MARK;
      res.back_value  = EMPTY_MARK;
    end else begin
      res.front_value = deque_slots[head_slot];
      res.back_value  = deque_slots[(head_slot + live_count - 1) % deq_pkg::CAPACITY];
    end
    res.entry_count = CW'(live_count);
    res.is_empty    = (live_count == 0);
    return res;
  endfunction

  function automatic logic [OPW-1:0] pick_op(input burst_mode_e mode);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        push_pct = 80;
        pop_pct  = 15;
      end
      MODE_DRAIN: begin
        push_pct = 15;
        pop_pct  = 80;
      end
      default: begin
        push_pct = 45;
        pop_pct  = 45;
      end
    endcase
    if (r < push_pct) begin
      return ($urandom_range(0, 1) != 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    end else if (r < push_pct + pop_pct) begin
      return ($urandom_range(0, 1) != 0) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    end
    return OPW'($urandom_range(deq_pkg::OP_QUERY, OP_SPARE_7));
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2:       return EMPTY_MARK;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(input logic [OPW-1:0] op, input logic signed [DW-1:0] value,
                         input bit typed, input deque_view_t want);
    int gap;
    deque_view_t predicted;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    push_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predicted = apply_deque_op(op, value);
    predicted_views = {predicted_views, (typed ? want : predicted)};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (predicted_views.size() != 0);
  endtask

  task automatic check_result();
    deque_view_t want;
    if (predicted_views.size() == 0) begin
      mismatch_count++;
      $error("result with no transaction outstanding");
    end else begin
      want = predicted_views[0];
      predicted_views.delete(0);
      if (front_value_o !== want.front_value) begin
        mismatch_count++;
        $error("front_value: expected %0d, got %0d", want.front_value, front_value_o);
      end
      if (back_value_o !== want.back_value) begin
        mismatch_count++;
        $error("back_value: expected %0d, got %0d", want.back_value, back_value_o);
      end
      if (entry_count_o !== want.entry_count) begin
        mismatch_count++;
        $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
      end
      if (is_empty_o !== want.is_empty) begin
        mismatch_count++;
        $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty_o);
      end
      if (status_o !== want.status) begin
        mismatch_count++;
        $error("status: expected %0d, got %0d", want.status, status_o);
      end
    end
  endtask

  task automatic run_stimulus();
    int idle_pcts [4] = '{0, 74, 0, 38};
    int stall_pcts [4] = '{0, 0, 74, 38};
    int sent;
    int len;
    burst_mode_e mode;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_op(directed_rows[r].op, directed_rows[r].value + k,
                directed_rows[r].typed, directed_rows[r].want);
      end
    end
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      sender_idle_pct    = idle_pcts[phase];
      receiver_stall_pct = stall_pcts[phase];
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        mode = burst_mode_e'($urandom_range(MODE_FILL, MODE_MIX));
        len  = $urandom_range(4, 40);
        repeat (len) send_op(pick_op(mode), pick_value(), 1'b0, NO_CHECK);
        sent += len;
      end
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result();
    end
  end

  initial begin
    fork
      run_stimulus();
      begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
          @(posedge clk_i);
          if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
            quiet = 0;
          end else begin
            quiet++;
          end
        end
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatch_count == 0 && predicted_views.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue.sv
bench/tb_double_ended_queue.sv
